/* rtl/core/u8dec_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned CNT_W  = 2;

    // Lead byte classes, compared under their masks.
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_VAL   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;

    // Payload masks.
    localparam logic [BYTE_W-1:0] PAY2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] PAY3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] PAY4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] PAYC_MASK = 8'h3F;

    // Surrogate window check for four-byte results.
    localparam logic [CP_W-1:0] SURR_MASK = 21'h1FF800;
    localparam logic [CP_W-1:0] SURR_VAL  = 21'h00D800;

    // Continuation bytes still expected after each lead.
    localparam logic [CNT_W-1:0] PEND_NONE = 2'd0;
    localparam logic [CNT_W-1:0] PEND_TWO  = 2'd1;
    localparam logic [CNT_W-1:0] PEND_THR  = 2'd2;
    localparam logic [CNT_W-1:0] PEND_FOUR = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] pending;
        logic [CP_W-1:0]  partial;
        logic             four;
    } seq_state_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            done;
        logic            bad;
    } result_t;

    localparam seq_state_t SEQ_IDLE = '{pending: PEND_NONE, partial: '0, four: 1'b0};

endpackage

`default_nettype wire

/* rtl/core/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: input register, decode, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | sink      | in_valid / in_stall  | in_byte[7:0]
//  out     | source    | out_valid / out_stall| code_point[20:0], done_res, bad_sequence
//
//  One beat in gives exactly one beat out. Throughput is one byte per clock
//  while out is not stalled; a byte passes the input register, then the result register.
//  The sequence state (pending count, partial value, four-byte flag) is
//  updated when a byte moves from the input register into the result
//  register, so consecutive bytes decode back to back through the feedback.
//  rst_n clears both valid flags and the sequence state asynchronously.
//  A stall on out holds the result register; in_stall rises only when the
//  input register is full and cannot move forward in the same cycle.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [u8dec_pkg::BYTE_W-1:0]  in_byte,

    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [u8dec_pkg::CP_W-1:0]    code_point,
    output      logic                          done_res,
    output      logic                          bad_sequence
);

    // Input register.
    logic                          s1_valid_reg;
    logic [u8dec_pkg::BYTE_W-1:0]  s1_byte_reg;

    // Result register.
    logic                          s2_valid_reg;
    u8dec_pkg::result_t            s2_res_reg;

    // Sequence state carried between bytes.
    u8dec_pkg::seq_state_t         seq_reg;
    u8dec_pkg::seq_state_t         seq_next;
    u8dec_pkg::result_t            res_next;

    logic                          s2_take;
    logic                          s1_take;

    // Advance the result register when it is empty or being drained.
    assign s2_take  = !s2_valid_reg || !out_stall;
    // Advance the input register when it is empty or moving forward.
    assign s1_take  = !s1_valid_reg || s2_take;
    assign in_stall = !s1_take;

    u8dec_step u_step (
        .in_byte (s1_byte_reg),
        .cur     (seq_reg),
        .nxt     (seq_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            seq_reg      <= u8dec_pkg::SEQ_IDLE;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            // Commit the decoded state only when the byte leaves the input register.
            if (s1_valid_reg && s2_take)
            begin
                seq_reg <= seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && in_valid)
        begin
            s1_byte_reg <= in_byte;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_res_reg <= res_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign code_point   = s2_res_reg.code_point;
    assign done_res     = s2_res_reg.done;
    assign bad_sequence = s2_res_reg.bad;

`ifndef NO_ASSERTIONS
    // A result that is not a code point carries a zero value.
    a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (code_point == '0))
        else $error("code_point nonzero without done_res");

    // Done with an error together only comes from a byte re-decoded as ASCII.
    a_done_bad_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res && bad_sequence) |-> (code_point[u8dec_pkg::CP_W-1:7] == '0))
        else $error("done with error on a non-ASCII code point");

    // No sequence open means no partial value and no four-byte mark.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg.pending == u8dec_pkg::PEND_NONE) |-> (seq_reg.partial == '0 && !seq_reg.four))
        else $error("idle sequence state holds stale payload");

    // A stalled result stays in the result register.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_stall) |=> (s2_valid_reg && $stable(s2_res_reg)))
        else $error("result register changed under stall");
`endif

endmodule

`default_nettype wire

/* rtl/core/u8dec_step.sv */
// Combinational decode of one byte against the open sequence state.
`default_nettype none

module u8dec_step (
    input  wire logic [u8dec_pkg::BYTE_W-1:0] in_byte,
    input  wire u8dec_pkg::seq_state_t         cur,
    output u8dec_pkg::seq_state_t              nxt,
    output u8dec_pkg::result_t                 res
);

    logic                          as_lead;
    logic                          is_cont;
    logic [u8dec_pkg::CP_W-1:0]    shifted;
    logic [u8dec_pkg::CNT_W-1:0]   pend_dec;

    assign is_cont  = (in_byte & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_VAL;
    assign shifted  = {cur.partial[u8dec_pkg::CP_W-7:0],
                       in_byte[5:0] & u8dec_pkg::PAYC_MASK[5:0]};
    assign pend_dec = cur.pending - u8dec_pkg::CNT_W'(1);

    always_comb
    begin
        nxt     = cur;
        res     = '0;
        as_lead = 1'b1;

        if (cur.pending != u8dec_pkg::PEND_NONE)
        begin
            if (is_cont)
            begin
                as_lead     = 1'b0;
                nxt.partial = shifted;
                nxt.pending = pend_dec;
                if (pend_dec == u8dec_pkg::PEND_NONE)
                begin
                    // Reject surrogates that arrive in four-byte form.
                    if (cur.four && ((shifted & u8dec_pkg::SURR_MASK) == u8dec_pkg::SURR_VAL))
                    begin
                        res.bad = 1'b1;
                    end
                    else
                    begin
                        res.done       = 1'b1;
                        res.code_point = shifted;
                    end
                    nxt = u8dec_pkg::SEQ_IDLE;
                end
            end
            else
            begin
                // Drop the partial value; the byte is decoded again as a lead.
                res.bad = 1'b1;
                nxt     = u8dec_pkg::SEQ_IDLE;
            end
        end

        if (as_lead)
        begin
            if ((in_byte & u8dec_pkg::ASCII_MASK) == '0)
            begin
                res.done       = 1'b1;
                res.code_point = u8dec_pkg::CP_W'(in_byte);
            end
            else if ((in_byte & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_VAL)
            begin
                nxt.pending = u8dec_pkg::PEND_TWO;
                nxt.partial = u8dec_pkg::CP_W'(in_byte & u8dec_pkg::PAY2_MASK);
                nxt.four    = 1'b0;
            end
            else if ((in_byte & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_VAL)
            begin
                nxt.pending = u8dec_pkg::PEND_THR;
                nxt.partial = u8dec_pkg::CP_W'(in_byte & u8dec_pkg::PAY3_MASK);
                nxt.four    = 1'b0;
            end
            else if ((in_byte & u8dec_pkg::LEAD4_MASK) == u8dec_pkg::LEAD4_VAL)
            begin
                nxt.pending = u8dec_pkg::PEND_FOUR;
                nxt.partial = u8dec_pkg::CP_W'(in_byte & u8dec_pkg::PAY4_MASK);
                nxt.four    = 1'b1;
            end
            else
            begin
                res.bad = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* dv/utf8_stream_decoder_chk.sv */
// Checker for the UTF-8 stream decoder: byte-level decode predictor and result scoreboard.
`default_nettype none

module utf8_stream_decoder_chk
    import u8dec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [CP_W-1:0]   code_point,
    input  wire logic              done_res,
    input  wire logic              bad_sequence,
    output int unsigned            fail_count,
    output int unsigned            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted sequence state.
    logic [CNT_W-1:0] seq_left;
    logic [CP_W-1:0]  seq_acc;
    logic             seq_four;

    result_t decoded_q [$];

    // Decode one byte against the predicted state and advance it.
    function automatic result_t decode_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        logic    as_lead;
        r       = '0;
        as_lead = 1'b1;
        if (seq_left != PEND_NONE) begin
            if ((b & CONT_MASK) == CONT_VAL) begin
                as_lead  = 1'b0;
                seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
                seq_left = seq_left - 1'b1;
                if (seq_left == PEND_NONE) begin
                    // a four-byte form landing in the surrogate window is rejected
                    if (seq_four && ((seq_acc & SURR_MASK) == SURR_VAL)) begin
                        r.bad = 1'b1;
                    end
                    else begin
                        r.done       = 1'b1;
                        r.code_point = seq_acc;
                    end
                    seq_acc  = '0;
                    seq_four = 1'b0;
                end
            end
            else begin
                // drop the partial value; the byte is retried as a lead below
                r.bad    = 1'b1;
                seq_left = PEND_NONE;
                seq_acc  = '0;
                seq_four = 1'b0;
            end
        end
        if (as_lead) begin
            if ((b & ASCII_MASK) == '0) begin
                r.done       = 1'b1;
                r.code_point = CP_W'(b);
            end
            else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
                seq_left = PEND_TWO;
                seq_acc  = CP_W'(b & PAY2_MASK);
                seq_four = 1'b0;
            end
            else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
                seq_left = PEND_THR;
                seq_acc  = CP_W'(b & PAY3_MASK);
                seq_four = 1'b0;
            end
            else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
                seq_left = PEND_FOUR;
                seq_acc  = CP_W'(b & PAY4_MASK);
                seq_four = 1'b1;
            end
            else begin
                r.bad = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            seq_left    = PEND_NONE;
            seq_acc     = '0;
            seq_four    = 1'b0;
            decoded_q   = {};
            fail_count  = 0;
            outstanding = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                decoded_q.push_back(decode_byte(in_byte));
            end
            if (out_valid && !out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("result beat with nothing expected: code_point %h done %b bad %b",
                           code_point, done_res, bad_sequence);
                    fail_count++;
                end
                else begin
                    want = decoded_q.pop_front();
                    if (code_point !== want.code_point) begin
                        $error("code_point mismatch: expected %h, actual %h",
                               want.code_point, code_point);
                        fail_count++;
                    end
                    if (done_res !== want.done) begin
                        $error("done_res mismatch: expected %b, actual %b",
                               want.done, done_res);
                        fail_count++;
                    end
                    if (bad_sequence !== want.bad) begin
                        $error("bad_sequence mismatch: expected %b, actual %b",
                               want.bad, bad_sequence);
                        fail_count++;
                    end
                end
            end
            outstanding = decoded_q.size();
        end
    end

endmodule

`default_nettype wire

/* dv/utf8_stream_decoder_tb.sv */
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus, verdict.
`default_nettype none

module utf8_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Length of the receiver hold-off used to back the block up.
    localparam int HOLD_CYCLES   = 300;
    localparam int BYTES_PER_PHASE = 400;

    // Directed bytes: field extremes, each sequence length, stray continuation,
    // invalid leads, mismatches into ASCII / a new lead / an invalid byte,
    // a four-byte surrogate, and an overlong two-byte NUL.
    localparam logic [u8dec_pkg::BYTE_W-1:0] DIRECTED [27] = '{
        8'h00, 8'h7F,
        8'hC2, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'h80,
        8'hF8,
        8'hFF,
        8'hC3, 8'h41,
        8'hE2, 8'hC3, 8'hA9,
        8'hE2, 8'hFF,
        8'hF0, 8'h8D, 8'hA0, 8'h80,
        8'hC0, 8'h80
    };

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic [u8dec_pkg::BYTE_W-1:0]   in_byte   = '0;
    logic                           out_stall = 1'b0;
    logic                           in_stall;
    logic                           out_valid;
    logic [u8dec_pkg::CP_W-1:0]     code_point;
    logic                           done_res;
    logic                           bad_sequence;

    int unsigned fail_count;
    int unsigned outstanding;

    // Idle rates in percent, changed per phase by the stimulus process.
    int gap_pct   = 0;
    int stall_pct = 0;

    // Hold-off handshake: stimulus bumps hold_req, the receiver process acks it.
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    int bytes_sent = 0;

    always #5 clk = ~clk;

    utf8_stream_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_point   (code_point),
        .done_res     (done_res),
        .bad_sequence (bad_sequence)
    );

    utf8_stream_decoder_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_point   (code_point),
        .done_res     (done_res),
        .bad_sequence (bad_sequence),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // Receiver: hold off for a long stretch when asked, else stall at random.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_ack  <= hold_req;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Offer one beat; called and returning just after a falling edge.
    // Keep idling while a draw falls under the sender's rate, then hold the byte until accepted.
    task automatic send_byte(input logic [u8dec_pkg::BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Send one random character: mostly well-formed with random payload,
    // some cut short so the next lead lands mid-sequence, some raw noise.
    task automatic send_char();
        int                             kind;
        int                             len;
        int                             cnt;
        logic [u8dec_pkg::CP_W-1:0]     p;
        logic [u8dec_pkg::BYTE_W-1:0]   seq [4];
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        p    = u8dec_pkg::CP_W'($urandom);
        case (len)
            1: seq[0] = {1'b0, p[6:0]};
            2: seq[0] = {3'b110, p[10:6]};
            3: seq[0] = {4'b1110, p[15:12]};
            default:
            begin
                // steer some four-byte forms into the surrogate window
                if ($urandom_range(0, 9) == 0)
                begin
                    p[20:11] = u8dec_pkg::SURR_VAL[20:11];
                end
                seq[0] = {5'b11110, p[20:18]};
            end
        endcase
        seq[1] = {2'b10, (len == 2) ? p[5:0] : (len == 3) ? p[11:6] : p[17:12]};
        seq[2] = {2'b10, (len == 3) ? p[5:0] : p[11:6]};
        seq[3] = {2'b10, p[5:0]};
        if (kind < 80)
        begin
            cnt = len;
        end
        else if (kind < 90)
        begin
            cnt = (len == 1) ? 1 : $urandom_range(1, len - 1);
        end
        else
        begin
            seq[0] = u8dec_pkg::BYTE_W'($urandom_range(0, 255));
            cnt    = 1;
        end
        for (int i = 0; i < cnt; i++)
        begin
            send_byte(seq[i]);
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase 1: sender idles lightly, receiver stalls half the time.
        gap_pct   = 23;
        stall_pct = 49;
        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i]);
        end
        while (bytes_sent < BYTES_PER_PHASE) send_char();

        // Phase 2: swap the idle rates.
        gap_pct   = 49;
        stall_pct = 23;
        while (bytes_sent < 2 * BYTES_PER_PHASE) send_char();

        // Phase 3: full rate both ways; open with a long receiver hold-off
        // while bytes keep coming so the block fills and stalls its input.
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = hold_req + 1;
        while (bytes_sent < 3 * BYTES_PER_PHASE) send_char();

        in_valid <= 1'b0;

        // Drain, then keep the clock running so anything unexpected can still show up.
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
